FILE: src/rv32i_instruction_decoder_defines.svh
// Assertion macros used by the decoder RTL.
`ifndef RV32I_INSTRUCTION_DECODER_DEFINES_SVH
`define RV32I_INSTRUCTION_DECODER_DEFINES_SVH

// Clocked property, switched off while reset is held.
`define RVID_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked implication, switched off while reset is held.
`define RVID_ASSERT_IMPL(label, cond, conseq, msg) \
    `RVID_ASSERT(label, (cond) |-> (conseq), msg)

`endif

FILE: src/rvid_pkg.sv
// ----------------------------------------------------------------------------
// RV32I decoder package
// Format and operation codes and the decoded result type.
// ----------------------------------------------------------------------------
package rvid_pkg;

    localparam logic [2:0] FMT_R    = 3'd0;
    localparam logic [2:0] FMT_I    = 3'd1;
    localparam logic [2:0] FMT_S    = 3'd2;
    localparam logic [2:0] FMT_B    = 3'd3;
    localparam logic [2:0] FMT_U    = 3'd4;
    localparam logic [2:0] FMT_J    = 3'd5;
    localparam logic [2:0] FMT_NONE = 3'd7;

    localparam logic [4:0] OP_BEQ   = 5'd0;
    localparam logic [4:0] OP_BNE   = 5'd1;
    localparam logic [4:0] OP_BLT   = 5'd2;
    localparam logic [4:0] OP_BGE   = 5'd3;
    localparam logic [4:0] OP_BLTU  = 5'd4;
    localparam logic [4:0] OP_BGEU  = 5'd5;
    localparam logic [4:0] OP_ADDI  = 5'd6;
    localparam logic [4:0] OP_SLTI  = 5'd7;
    localparam logic [4:0] OP_SLTIU = 5'd8;
    localparam logic [4:0] OP_XORI  = 5'd9;
    localparam logic [4:0] OP_ORI   = 5'd10;
    localparam logic [4:0] OP_ANDI  = 5'd11;
    localparam logic [4:0] OP_SLLI  = 5'd12;
    localparam logic [4:0] OP_SRLI  = 5'd13;
    localparam logic [4:0] OP_SRAI  = 5'd14;
    localparam logic [4:0] OP_ADD   = 5'd15;
    localparam logic [4:0] OP_SUB   = 5'd16;
    localparam logic [4:0] OP_SLL   = 5'd17;
    localparam logic [4:0] OP_SLT   = 5'd18;
    localparam logic [4:0] OP_SLTU  = 5'd19;
    localparam logic [4:0] OP_XOR   = 5'd20;
    localparam logic [4:0] OP_SRL   = 5'd21;
    localparam logic [4:0] OP_SRA   = 5'd22;
    localparam logic [4:0] OP_OR    = 5'd23;
    localparam logic [4:0] OP_AND   = 5'd24;
    localparam logic [4:0] OP_LUI   = 5'd25;
    localparam logic [4:0] OP_AUIPC = 5'd26;
    localparam logic [4:0] OP_JAL   = 5'd27;
    localparam logic [4:0] OP_JALR  = 5'd28;
    localparam logic [4:0] OP_LOAD  = 5'd29;
    localparam logic [4:0] OP_STORE = 5'd30;
    localparam logic [4:0] OP_NONE  = 5'd31;

    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_JAL    = 7'h6F;

    typedef struct packed {
        logic               illegal;
        logic [2:0]         format_kind;
        logic [4:0]         op_kind;
        logic [4:0]         dest_index;
        logic [4:0]         src1_index;
        logic [4:0]         src2_index;
        logic signed [31:0] immediate;
        logic               dest_used;
        logic               src1_used;
        logic               src2_used;
        logic               imm_used;
    } t_result;

endpackage

FILE: src/rvid_decode.sv
// ----------------------------------------------------------------------------
// RV32I decode logic
// Works out format, operation, register indices, immediate, usage flags and the illegal flag.
// ----------------------------------------------------------------------------
module rvid_decode (
    input  logic [31:0]      i_word,
    output rvid_pkg::t_result o_result
);

    logic [2:0] w_fmt;
    logic [4:0] w_op;
    logic [2:0] w_f3;
    logic       w_b30;
    logic [31:0] w_sign;
    logic [31:0] w_imm;

    assign w_f3   = i_word[14:12];
    assign w_b30  = i_word[30];
    assign w_sign = {32{i_word[31]}};

    always_comb begin
        case (i_word[6:2])
            5'h0B, 5'h14, 5'h0C, 5'h0E:        w_fmt = rvid_pkg::FMT_R;
            5'h00, 5'h01, 5'h04, 5'h06, 5'h19: w_fmt = rvid_pkg::FMT_I;
            5'h08, 5'h09:                      w_fmt = rvid_pkg::FMT_S;
            5'h18:                             w_fmt = rvid_pkg::FMT_B;
            5'h05, 5'h0D:                      w_fmt = rvid_pkg::FMT_U;
            5'h1B:                             w_fmt = rvid_pkg::FMT_J;
            default:                           w_fmt = rvid_pkg::FMT_NONE;
        endcase
    end

    always_comb begin
        w_op = rvid_pkg::OP_NONE;
        case (i_word[6:0])
            rvid_pkg::OPC_BRANCH: begin
                case (w_f3)
                    3'd0:    w_op = rvid_pkg::OP_BEQ;
                    3'd1:    w_op = rvid_pkg::OP_BNE;
                    3'd4:    w_op = rvid_pkg::OP_BLT;
                    3'd5:    w_op = rvid_pkg::OP_BGE;
                    3'd6:    w_op = rvid_pkg::OP_BLTU;
                    3'd7:    w_op = rvid_pkg::OP_BGEU;
                    default: w_op = rvid_pkg::OP_NONE;
                endcase
            end
            rvid_pkg::OPC_OPIMM: begin
                case (w_f3)
                    3'd0:    w_op = rvid_pkg::OP_ADDI;
                    3'd1:    w_op = w_b30 ? rvid_pkg::OP_NONE : rvid_pkg::OP_SLLI;
                    3'd2:    w_op = rvid_pkg::OP_SLTI;
                    3'd3:    w_op = rvid_pkg::OP_SLTIU;
                    3'd4:    w_op = rvid_pkg::OP_XORI;
                    3'd5:    w_op = w_b30 ? rvid_pkg::OP_SRAI : rvid_pkg::OP_SRLI;
                    3'd6:    w_op = rvid_pkg::OP_ORI;
                    default: w_op = rvid_pkg::OP_ANDI;
                endcase
            end
            rvid_pkg::OPC_OP: begin
                case (w_f3)
                    3'd0:    w_op = w_b30 ? rvid_pkg::OP_SUB : rvid_pkg::OP_ADD;
                    3'd1:    w_op = w_b30 ? rvid_pkg::OP_NONE : rvid_pkg::OP_SLL;
                    3'd2:    w_op = w_b30 ? rvid_pkg::OP_NONE : rvid_pkg::OP_SLT;
                    3'd3:    w_op = w_b30 ? rvid_pkg::OP_NONE : rvid_pkg::OP_SLTU;
                    3'd4:    w_op = w_b30 ? rvid_pkg::OP_NONE : rvid_pkg::OP_XOR;
                    3'd5:    w_op = w_b30 ? rvid_pkg::OP_SRA : rvid_pkg::OP_SRL;
                    3'd6:    w_op = w_b30 ? rvid_pkg::OP_NONE : rvid_pkg::OP_OR;
                    default: w_op = w_b30 ? rvid_pkg::OP_NONE : rvid_pkg::OP_AND;
                endcase
            end
            rvid_pkg::OPC_LUI:   w_op = rvid_pkg::OP_LUI;
            rvid_pkg::OPC_AUIPC: w_op = rvid_pkg::OP_AUIPC;
            rvid_pkg::OPC_JAL:   w_op = rvid_pkg::OP_JAL;
            rvid_pkg::OPC_JALR:  w_op = (w_f3 == 3'd0) ? rvid_pkg::OP_JALR
                                                       : rvid_pkg::OP_NONE;
            rvid_pkg::OPC_LOAD:  w_op = rvid_pkg::OP_LOAD;
            rvid_pkg::OPC_STORE: w_op = rvid_pkg::OP_STORE;
            default:             w_op = rvid_pkg::OP_NONE;
        endcase
    end

    always_comb begin
        case (w_fmt)
            rvid_pkg::FMT_I: w_imm = (w_sign & 32'hFFFFF800) | {21'd0, i_word[30:20]};
            rvid_pkg::FMT_S: w_imm = (w_sign & 32'hFFFFF800)
                                   | {21'd0, i_word[30:25], i_word[11:7]};
            rvid_pkg::FMT_B: w_imm = (w_sign & 32'hFFFFF000)
                                   | {20'd0, i_word[7], i_word[30:25], i_word[11:8], 1'b0};
            rvid_pkg::FMT_U: w_imm = {i_word[31:12], 12'd0};
            rvid_pkg::FMT_J: w_imm = (w_sign & 32'hFFF00000)
                                   | {12'd0, i_word[19:12], i_word[20], i_word[30:21], 1'b0};
            default:         w_imm = 32'd0;
        endcase
    end

    always_comb begin
        o_result = '0;
        if ((w_fmt == rvid_pkg::FMT_NONE) || (w_op == rvid_pkg::OP_NONE)) begin
            o_result.illegal = 1'b1;
        end else begin
            o_result.format_kind = w_fmt;
            o_result.op_kind     = w_op;
            o_result.dest_index  = i_word[11:7];
            o_result.src1_index  = i_word[19:15];
            o_result.src2_index  = i_word[24:20];
            o_result.immediate   = w_imm;
            o_result.dest_used   = ((w_fmt == rvid_pkg::FMT_R) || (w_fmt == rvid_pkg::FMT_I)
                                 || (w_fmt == rvid_pkg::FMT_U) || (w_fmt == rvid_pkg::FMT_J))
                                 && (i_word[11:7] != 5'd0);
            o_result.src1_used   = (w_fmt == rvid_pkg::FMT_R) || (w_fmt == rvid_pkg::FMT_I)
                                 || (w_fmt == rvid_pkg::FMT_S) || (w_fmt == rvid_pkg::FMT_B);
            o_result.src2_used   = (w_fmt == rvid_pkg::FMT_R) || (w_fmt == rvid_pkg::FMT_S)
                                 || (w_fmt == rvid_pkg::FMT_B);
            o_result.imm_used    = (w_fmt != rvid_pkg::FMT_R);
        end
    end

endmodule

FILE: src/rv32i_instruction_decoder.sv
// ----------------------------------------------------------------------------
// RV32I instruction decoder
// An accepted word is held in the input register, decoded, and registered into
// the result register that drives the output. Throughput is one item per cycle
// while the output is not stalled: an input register and a result register
// each hold one item, and the decode logic between them is purely combinational.
// Reset clears both valid flags synchronously; payload registers are not reset.
// ----------------------------------------------------------------------------
`include "rv32i_instruction_decoder_defines.svh"

module rv32i_instruction_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // instr_word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // dest_index, src1_index, src2_index, immediate, dest_used, src1_used,
    // src2_used, imm_used, zero padding
    output logic [55:0] m_axis_tdata,
    output logic [8:0]  m_axis_tuser    // illegal, format_kind, op_kind
);

    logic              r_in_valid;
    logic [31:0]       r_in_word;
    logic              r_out_valid;
    rvid_pkg::t_result r_out;
    rvid_pkg::t_result n_result;
    logic              w_out_ready;

    rvid_decode u_decode (
        .i_word   (r_in_word),
        .o_result (n_result)
    );

    assign w_out_ready   = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_out_ready) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_word <= s_axis_tdata;
        end
        if (r_in_valid && w_out_ready) begin
            r_out <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = {r_out.op_kind, r_out.format_kind, r_out.illegal};
    assign m_axis_tdata  = {5'd0, r_out.imm_used, r_out.src2_used, r_out.src1_used,
                            r_out.dest_used, r_out.immediate, r_out.src2_index,
                            r_out.src1_index, r_out.dest_index};

    `RVID_ASSERT_IMPL(a_illegal_clears_data, r_out_valid && r_out.illegal,
                      m_axis_tdata == 56'd0, "illegal item carries nonzero data")
    `RVID_ASSERT_IMPL(a_stage_advances, r_in_valid && w_out_ready, ##1 r_out_valid,
                      "decoded item did not reach the result register")
    `RVID_ASSERT_IMPL(a_full_stalls_input, r_in_valid && r_out_valid && !m_axis_tready,
                      !s_axis_tready, "input taken while both stages are full")
    `RVID_ASSERT_IMPL(a_dest_nonzero, r_out_valid && r_out.dest_used,
                      r_out.dest_index != 5'd0, "destination marked used with index zero")
    `RVID_ASSERT_IMPL(a_rformat_no_imm,
                      r_out_valid && !r_out.illegal && (r_out.format_kind == rvid_pkg::FMT_R),
                      !r_out.imm_used && (r_out.immediate == 32'sd0),
                      "R format item carries an immediate")

endmodule
